/* sv/svpwm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared constants and inter-stage sideband types for the min-max SVPWM core.
// ----------------------------------------------------------------------------
package svpwm_pkg;

  localparam int VoltW   = 16;
  localparam int PeriodW = 16;

  // Q15 fixed-point constants
  localparam logic [15:0] INV_SQRT3_Q15 = 16'd18919;
  localparam logic [17:0] COS30_X2      = 18'd56756;   // 2 * 0.866 in Q15, sign bit clear
  localparam logic [PeriodW-1:0] PERIOD_RESET = 16'hFFFF;

  // register port byte addresses
  localparam logic [1:0] ADDR_PERIOD = 2'd0;

  // carried alongside the square-root stages
  typedef struct packed {
    logic [2*VoltW-1:0] na;     // |alpha| * vmax
    logic [2*VoltW-1:0] nb;     // |beta| * vmax
    logic               lim;
    logic               fault;
    logic [VoltW-1:0]   a;
    logic [VoltW-1:0]   b;
    logic [VoltW-1:0]   vdc;
  } sq_tag_t;

  // carried alongside the alpha limiter divider
  typedef struct packed {
    logic             lim;
    logic             fault;
    logic [VoltW-1:0] a;
    logic [VoltW-1:0] vdc;
  } lim_tag_t;

  // carried alongside the compare dividers
  typedef struct packed {
    logic le0;   // phase term at or below zero
    logic ge;    // phase term at or above full scale
  } cmp_tag_t;

  typedef struct packed {
    logic     fault;
    logic     lim;
    cmp_tag_t cmp;
  } cmp0_tag_t;

endpackage

/* sv/svpwm_min_max_duty_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_min_max_duty_core
// Space-vector PWM with min-max injection: limits the (alpha, beta) vector to
// vdc/sqrt3, inverse-Clarke transforms it, removes the min-max common mode and
// maps each phase to a timer compare count for the programmed period.
// ----------------------------------------------------------------------------
// Fully pipelined: a new item is taken every cycle unless the output stalls,
// and passes 59 register stages before its result is offered.
// The depth is set by four front stages, the 16-stage square root, the
// 16-stage limiter dividers, six phase stages, the 16-stage compare dividers
// and the output register. A stall at the output while a result waits freezes
// the whole pipeline and is seen at in_stall_o in the same cycle.
// pwm_period sits at byte address 0 of the register port.
module svpwm_min_max_duty_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] volt_alpha_i,
  input  logic [15:0] volt_beta_i,
  input  logic [15:0] bus_voltage_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] compare_a_o,
  output logic [15:0] compare_b_o,
  output logic [15:0] compare_c_o,
  output logic        was_limited_o,
  output logic        bus_fault_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int VW = svpwm_pkg::VoltW;
  localparam int PW = svpwm_pkg::PeriodW;

  logic en;
  logic [PW-1:0] period_q;

  // ---------------- register port ----------------
  assign pready = 1'b1;
  assign prdata = {{(32-PW){1'b0}}, period_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= svpwm_pkg::PERIOD_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == svpwm_pkg::ADDR_PERIOD)) begin
      period_q <= pwdata[PW-1:0];
    end
  end

  // ---------------- flow control ----------------
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // ---------------- S1: capture ----------------
  logic          s1_v_q;
  logic [VW-1:0] s1_a_q, s1_b_q, s1_vdc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a_q   <= volt_alpha_i;
      s1_b_q   <= volt_beta_i;
      s1_vdc_q <= bus_voltage_i;
    end
  end

  // ---------------- S2: squares and vmax ----------------
  logic signed [2*VW-1:0] s1_asq, s1_bsq;
  logic [2*VW-1:0]        s1_vprod;
  logic                   s2_v_q;
  logic [2*VW-1:0]        s2_asq_q, s2_bsq_q;
  logic [VW-1:0]          s2_vmax_q, s2_a_q, s2_b_q, s2_vdc_q;

  assign s1_asq   = $signed(s1_a_q) * $signed(s1_a_q);
  assign s1_bsq   = $signed(s1_b_q) * $signed(s1_b_q);
  assign s1_vprod = (2*VW)'(s1_vdc_q) * (2*VW)'(svpwm_pkg::INV_SQRT3_Q15);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_asq_q  <= s1_asq;
      s2_bsq_q  <= s1_bsq;
      s2_vmax_q <= s1_vprod[VW+14:15];
      s2_a_q    <= s1_a_q;
      s2_b_q    <= s1_b_q;
      s2_vdc_q  <= s1_vdc_q;
    end
  end

  // ---------------- S3: magnitude, vmax^2, scaled numerators ----------------
  logic [VW-1:0]   s2_aabs, s2_babs;
  logic            s3_v_q;
  logic [2*VW-1:0] s3_mag2_q, s3_vmax2_q, s3_na_q, s3_nb_q;
  logic [VW-1:0]   s3_a_q, s3_b_q, s3_vdc_q;

  assign s2_aabs = s2_a_q[VW-1] ? VW'(0) - s2_a_q : s2_a_q;
  assign s2_babs = s2_b_q[VW-1] ? VW'(0) - s2_b_q : s2_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_mag2_q  <= s2_asq_q + s2_bsq_q;
      s3_vmax2_q <= (2*VW)'(s2_vmax_q) * (2*VW)'(s2_vmax_q);
      s3_na_q    <= (2*VW)'(s2_aabs) * (2*VW)'(s2_vmax_q);
      s3_nb_q    <= (2*VW)'(s2_babs) * (2*VW)'(s2_vmax_q);
      s3_a_q     <= s2_a_q;
      s3_b_q     <= s2_b_q;
      s3_vdc_q   <= s2_vdc_q;
    end
  end

  // ---------------- S4: limit decision ----------------
  logic                s4_v_q;
  logic [2*VW-1:0]     s4_mag2_q;
  svpwm_pkg::sq_tag_t  s4_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_mag2_q      <= s3_mag2_q;
      s4_tag_q.na    <= s3_na_q;
      s4_tag_q.nb    <= s3_nb_q;
      s4_tag_q.lim   <= (s3_mag2_q > s3_vmax2_q) && (s3_vdc_q != '0);
      s4_tag_q.fault <= s3_vdc_q == '0;
      s4_tag_q.a     <= s3_a_q;
      s4_tag_q.b     <= s3_b_q;
      s4_tag_q.vdc   <= s3_vdc_q;
    end
  end

  // ---------------- square root of magnitude ----------------
  logic               sq_v;
  logic [VW-1:0]      sq_root;
  svpwm_pkg::sq_tag_t sq_tag;

  svpwm_sqrt #(
    .NW (2*VW),
    .TW ($bits(svpwm_pkg::sq_tag_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .n_i     (s4_mag2_q),
    .tag_i   (s4_tag_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .tag_o   (sq_tag)
  );

  // ---------------- limiter dividers ----------------
  svpwm_pkg::lim_tag_t la_tag_in, la_tag;
  logic                la_v, lb_v;
  logic [VW-1:0]       la_q, lb_q, lb_tag;

  assign la_tag_in.lim   = sq_tag.lim;
  assign la_tag_in.fault = sq_tag.fault;
  assign la_tag_in.a     = sq_tag.a;
  assign la_tag_in.vdc   = sq_tag.vdc;

  svpwm_div #(
    .DW (VW),
    .QW (VW),
    .TW ($bits(svpwm_pkg::lim_tag_t))
  ) u_lim_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .n_i     (sq_tag.na),
    .d_i     (sq_root),
    .tag_i   (la_tag_in),
    .valid_o (la_v),
    .q_o     (la_q),
    .tag_o   (la_tag)
  );

  svpwm_div #(
    .DW (VW),
    .QW (VW),
    .TW (VW)
  ) u_lim_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .n_i     (sq_tag.nb),
    .d_i     (sq_root),
    .tag_i   (sq_tag.b),
    .valid_o (lb_v),
    .q_o     (lb_q),
    .tag_o   (lb_tag)
  );

  // ---------------- P1: apply limit ----------------
  logic          p1_v_q, p1_lim_q, p1_fault_q;
  logic [VW-1:0] p1_a_q, p1_b_q, p1_vdc_q;
  logic [VW-1:0] a_lim, b_lim;

  // restore the sign on the scaled magnitude
  assign a_lim = la_tag.a[VW-1] ? VW'(0) - la_q : la_q;
  assign b_lim = lb_tag[VW-1] ? VW'(0) - lb_q : lb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= la_v && lb_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_a_q     <= la_tag.lim ? a_lim : la_tag.a;
      p1_b_q     <= la_tag.lim ? b_lim : lb_tag;
      p1_vdc_q   <= la_tag.vdc;
      p1_lim_q   <= la_tag.lim;
      p1_fault_q <= la_tag.fault;
    end
  end

  // ---------------- P2: beta * 2cos30 ----------------
  logic signed [2*VW:0] p1_m;
  logic                 p2_v_q, p2_lim_q, p2_fault_q;
  logic [2*VW:0]        p2_m_q;
  logic [VW-1:0]        p2_a_q, p2_vdc_q;

  assign p1_m = $signed(p1_b_q) * $signed(svpwm_pkg::COS30_X2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (en) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_m_q     <= p1_m;
      p2_a_q     <= p1_a_q;
      p2_vdc_q   <= p1_vdc_q;
      p2_lim_q   <= p1_lim_q;
      p2_fault_q <= p1_fault_q;
    end
  end

  // ---------------- P3: inverse Clarke, doubled Q15 ----------------
  localparam int PHW = 2*VW + 2;

  logic [PHW-1:0] p2_a16, p2_a15, p2_m34;
  logic           p3_v_q, p3_lim_q, p3_fault_q;
  logic [PHW-1:0] p3_ph_q [3];
  logic [VW-1:0]  p3_vdc_q;

  assign p2_a16 = {{2{p2_a_q[VW-1]}}, p2_a_q, 16'b0};
  assign p2_a15 = {{3{p2_a_q[VW-1]}}, p2_a_q, 15'b0};
  assign p2_m34 = {p2_m_q[2*VW], p2_m_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else if (en) begin
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p3_ph_q[0] <= p2_a16;
      p3_ph_q[1] <= p2_m34 - p2_a15;
      p3_ph_q[2] <= PHW'(0) - p2_a15 - p2_m34;
      p3_vdc_q   <= p2_vdc_q;
      p3_lim_q   <= p2_lim_q;
      p3_fault_q <= p2_fault_q;
    end
  end

  // ---------------- P4: max + min ----------------
  logic [PHW-1:0] mx01, mn01, mx, mn;
  logic           p4_v_q, p4_lim_q, p4_fault_q;
  logic [PHW:0]   p4_sum_q;
  logic [PHW-1:0] p4_ph_q [3];
  logic [VW-1:0]  p4_vdc_q;

  always_comb begin
    mx01 = ($signed(p3_ph_q[1]) > $signed(p3_ph_q[0])) ? p3_ph_q[1] : p3_ph_q[0];
    mn01 = ($signed(p3_ph_q[1]) < $signed(p3_ph_q[0])) ? p3_ph_q[1] : p3_ph_q[0];
    mx   = ($signed(p3_ph_q[2]) > $signed(mx01)) ? p3_ph_q[2] : mx01;
    mn   = ($signed(p3_ph_q[2]) < $signed(mn01)) ? p3_ph_q[2] : mn01;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_v_q <= 1'b0;
    end else if (en) begin
      p4_v_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_sum_q   <= {mx[PHW-1], mx} + {mn[PHW-1], mn};
      p4_ph_q    <= p3_ph_q;
      p4_vdc_q   <= p3_vdc_q;
      p4_lim_q   <= p3_lim_q;
      p4_fault_q <= p3_fault_q;
    end
  end

  // ---------------- P5: remove common mode, add half bus ----------------
  localparam int TW = PHW + 2;

  logic           p5_v_q, p5_lim_q, p5_fault_q;
  logic [TW-1:0]  p5_t_q [3];
  logic [VW-1:0]  p5_vdc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p5_v_q <= 1'b0;
    end else if (en) begin
      p5_v_q <= p4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p5_t_q[k] <= {{2{p4_ph_q[k][PHW-1]}}, p4_ph_q[k]}
                     - {p4_sum_q[PHW], p4_sum_q}
                     + TW'({p4_vdc_q, 15'b0});
      end
      p5_vdc_q   <= p4_vdc_q;
      p5_lim_q   <= p4_lim_q;
      p5_fault_q <= p4_fault_q;
    end
  end

  // ---------------- P6: range flags and period product ----------------
  localparam int DENW = VW + 16;

  logic [DENW-1:0]         p5_den;
  logic                    p6_v_q, p6_lim_q, p6_fault_q;
  logic [DENW+PW-1:0]      p6_prod_q [3];
  svpwm_pkg::cmp_tag_t     p6_cmp_q [3];
  logic [DENW-1:0]         p6_den_q;

  assign p5_den = {p5_vdc_q, 16'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p6_v_q <= 1'b0;
    end else if (en) begin
      p6_v_q <= p5_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        p6_cmp_q[k].le0 <= p5_t_q[k][TW-1] || (p5_t_q[k] == '0);
        p6_cmp_q[k].ge  <= !p5_t_q[k][TW-1] && (p5_t_q[k] >= TW'(p5_den));
        p6_prod_q[k]    <= (DENW+PW)'(period_q) * (DENW+PW)'(p5_t_q[k][DENW-1:0]);
      end
      p6_den_q   <= p5_den;
      p6_lim_q   <= p5_lim_q;
      p6_fault_q <= p5_fault_q;
    end
  end

  // ---------------- compare dividers ----------------
  svpwm_pkg::cmp0_tag_t c0_tag_in, c0_tag;
  svpwm_pkg::cmp_tag_t  c1_tag, c2_tag;
  logic                 c0_v, c1_v, c2_v;
  logic [PW-1:0]        c0_q, c1_q, c2_q;

  assign c0_tag_in.fault = p6_fault_q;
  assign c0_tag_in.lim   = p6_lim_q;
  assign c0_tag_in.cmp   = p6_cmp_q[0];

  svpwm_div #(
    .DW (DENW),
    .QW (PW),
    .TW ($bits(svpwm_pkg::cmp0_tag_t))
  ) u_cmp_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p6_v_q),
    .n_i     (p6_prod_q[0]),
    .d_i     (p6_den_q),
    .tag_i   (c0_tag_in),
    .valid_o (c0_v),
    .q_o     (c0_q),
    .tag_o   (c0_tag)
  );

  svpwm_div #(
    .DW (DENW),
    .QW (PW),
    .TW ($bits(svpwm_pkg::cmp_tag_t))
  ) u_cmp_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p6_v_q),
    .n_i     (p6_prod_q[1]),
    .d_i     (p6_den_q),
    .tag_i   (p6_cmp_q[1]),
    .valid_o (c1_v),
    .q_o     (c1_q),
    .tag_o   (c1_tag)
  );

  svpwm_div #(
    .DW (DENW),
    .QW (PW),
    .TW ($bits(svpwm_pkg::cmp_tag_t))
  ) u_cmp_c (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (p6_v_q),
    .n_i     (p6_prod_q[2]),
    .d_i     (p6_den_q),
    .tag_i   (p6_cmp_q[2]),
    .valid_o (c2_v),
    .q_o     (c2_q),
    .tag_o   (c2_tag)
  );

  // ---------------- output register ----------------
  function automatic logic [PW-1:0] pick_cmp(
    input logic                fault,
    input svpwm_pkg::cmp_tag_t flags,
    input logic [PW-1:0]       quo,
    input logic [PW-1:0]       per
  );
    logic [PW-1:0] r;
    if (fault || flags.le0) begin
      r = '0;
    end else if (flags.ge) begin
      r = per;
    end else begin
      r = quo;
    end
    return r;
  endfunction

  logic [PW-1:0] cmp_a_q, cmp_b_q, cmp_c_q;
  logic          lim_q, fault_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= c0_v && c1_v && c2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmp_a_q <= pick_cmp(c0_tag.fault, c0_tag.cmp, c0_q, period_q);
      cmp_b_q <= pick_cmp(c0_tag.fault, c1_tag, c1_q, period_q);
      cmp_c_q <= pick_cmp(c0_tag.fault, c2_tag, c2_q, period_q);
      lim_q   <= c0_tag.lim;
      fault_q <= c0_tag.fault;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign compare_a_o   = cmp_a_q;
  assign compare_b_o   = cmp_b_q;
  assign compare_c_o   = cmp_c_q;
  assign was_limited_o = lim_q;
  assign bus_fault_o   = fault_q;

`ifndef SYNTHESIS
  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bus_fault_o |->
      compare_a_o == '0 && compare_b_o == '0 && compare_c_o == '0)
    else $error("bus fault item with nonzero compare");

  a_fault_not_limited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(bus_fault_o && was_limited_o))
    else $error("bus fault and limit flag set together");

  a_cmp_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      compare_a_o <= period_q && compare_b_o <= period_q && compare_c_o <= period_q)
    else $error("compare beyond period");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(compare_a_o))
    else $error("stalled output item changed");
`endif

endmodule

/* sv/svpwm_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_sqrt
// Pipelined integer square root, one result bit per stage, floor result.
// ----------------------------------------------------------------------------
module svpwm_sqrt #(
  parameter int NW = 32,
  parameter int TW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NW-1:0]   n_i,
  input  logic [TW-1:0]   tag_i,
  output logic            valid_o,
  output logic [NW/2-1:0] root_o,
  output logic [TW-1:0]   tag_o
);

  localparam int RW = NW / 2;

  logic [NW-1:0] rem_in [RW];
  logic [NW-1:0] res_in [RW];
  logic [TW-1:0] tag_in [RW];
  logic          v_in   [RW];

  logic [NW-1:0] rem_q [RW];
  logic [NW-1:0] res_q [RW];
  logic [TW-1:0] tag_q [RW];
  logic          v_q   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int BP = NW - 2 - 2 * k;
    logic [NW:0]   bitv;
    logic [NW:0]   trial;
    logic          take;
    logic [NW-1:0] rem_d;
    logic [NW-1:0] res_d;

    if (k == 0) begin : g_first
      assign rem_in[k] = n_i;
      assign res_in[k] = '0;
      assign tag_in[k] = tag_i;
      assign v_in[k]   = valid_i;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign res_in[k] = res_q[k-1];
      assign tag_in[k] = tag_q[k-1];
      assign v_in[k]   = v_q[k-1];
    end

    always_comb begin
      bitv  = (NW+1)'(1) << BP;
      trial = {1'b0, res_in[k]} + bitv;
      take  = {1'b0, rem_in[k]} >= trial;
      if (take) begin
        rem_d = NW'({1'b0, rem_in[k]} - trial);
        res_d = NW'(({1'b0, res_in[k]} >> 1) + bitv);
      end else begin
        rem_d = rem_in[k];
        res_d = res_in[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        res_q[k] <= res_d;
        tag_q[k] <= tag_in[k];
      end
    end
  end

  assign valid_o = v_q[RW-1];
  assign root_o  = res_q[RW-1][RW-1:0];
  assign tag_o   = tag_q[RW-1];

endmodule

/* sv/svpwm_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_div
// Pipelined restoring divider, one quotient bit per stage. The dividend must
// be below divisor * 2^QW so the quotient fits QW bits.
// ----------------------------------------------------------------------------
module svpwm_div #(
  parameter int DW = 32,
  parameter int QW = 16,
  parameter int TW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [DW+QW-1:0] n_i,
  input  logic [DW-1:0]   d_i,
  input  logic [TW-1:0]   tag_i,
  output logic            valid_o,
  output logic [QW-1:0]   q_o,
  output logic [TW-1:0]   tag_o
);

  logic [DW-1:0] rem_in [QW];
  logic [QW-1:0] lo_in  [QW];
  logic [QW-1:0] quo_in [QW];
  logic [DW-1:0] d_in   [QW];
  logic [TW-1:0] tag_in [QW];
  logic          v_in   [QW];

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] d_q   [QW];
  logic [TW-1:0] tag_q [QW];
  logic          v_q   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0]   trial;
    logic          take;
    logic [DW-1:0] rem_d;

    if (k == 0) begin : g_first
      assign rem_in[k] = n_i[DW+QW-1:QW];
      assign lo_in[k]  = n_i[QW-1:0];
      assign quo_in[k] = '0;
      assign d_in[k]   = d_i;
      assign tag_in[k] = tag_i;
      assign v_in[k]   = valid_i;
    end else begin : g_next
      assign rem_in[k] = rem_q[k-1];
      assign lo_in[k]  = lo_q[k-1];
      assign quo_in[k] = quo_q[k-1];
      assign d_in[k]   = d_q[k-1];
      assign tag_in[k] = tag_q[k-1];
      assign v_in[k]   = v_q[k-1];
    end

    always_comb begin
      trial = {rem_in[k], lo_in[k][QW-1]};
      take  = trial >= {1'b0, d_in[k]};
      if (take) begin
        rem_d = DW'(trial - {1'b0, d_in[k]});
      end else begin
        rem_d = trial[DW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        lo_q[k]  <= lo_in[k] << 1;
        quo_q[k] <= {quo_in[k][QW-2:0], take};
        d_q[k]   <= d_in[k];
        tag_q[k] <= tag_in[k];
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign q_o     = quo_q[QW-1];
  assign tag_o   = tag_q[QW-1];

endmodule

/* test/svpwm_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svpwm_checker
// Watches both item channels of the SVPWM core, predicts the three compare
// counts and flags of every accepted vector, and compares them in order.
// ----------------------------------------------------------------------------
module svpwm_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [15:0] volt_alpha_i,
  input  logic [15:0] volt_beta_i,
  input  logic [15:0] bus_voltage_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [15:0] compare_a_i,
  input  logic [15:0] compare_b_i,
  input  logic [15:0] compare_c_i,
  input  logic        was_limited_i,
  input  logic        bus_fault_i,
  input  logic [15:0] period_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [15:0] cmp_a;
    logic [15:0] cmp_b;
    logic [15:0] cmp_c;
    logic        lim;
    logic        fault;
  } duty_t;

  duty_t duty_q[$];

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned bits;
    res  = 0;
    bits = 64'd1 << 62;
    while (bits > n) bits >>= 2;
    while (bits != 0) begin
      if (n >= res + bits) begin
        n  -= res + bits;
        res = (res >> 1) + bits;
      end else begin
        res >>= 1;
      end
      bits >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] phase_count(longint t, longint unsigned per,
                                              longint unsigned den);
    longint unsigned q;
    if (t <= 0) return '0;
    if (longint'(den) <= t) return per[15:0];
    q = (per * longint'(t)) / den;   // fits: per < 2^16, t < 2^32
    return (q > per) ? per[15:0] : q[15:0];
  endfunction

  function automatic duty_t predict_duty(logic [15:0] va, logic [15:0] vb,
                                         logic [15:0] vbus, logic [15:0] per);
    duty_t r;
    longint a, b, vmax, mag2, s, mx, mn;
    longint ph[3];
    r = '0;
    if (vbus == 0) begin
      r.fault = 1'b1;
      return r;
    end
    a    = longint'($signed(va));
    b    = longint'($signed(vb));
    vmax = (longint'(vbus) * 18919) >>> 15;
    mag2 = a * a + b * b;
    if (mag2 > vmax * vmax) begin
      s = longint'(floor_sqrt(mag2));
      a = (a < 0) ? -((-a) * vmax / s) : (a * vmax / s);
      b = (b < 0) ? -((-b) * vmax / s) : (b * vmax / s);
      r.lim = 1'b1;
    end
    ph[0] = a * 65536;
    ph[1] = -(a * 32768) + 56756 * b;
    ph[2] = -(a * 32768) - 56756 * b;
    mx = ph[0];
    mn = ph[0];
    for (int k = 1; k < 3; k++) begin
      if (ph[k] > mx) mx = ph[k];
      if (ph[k] < mn) mn = ph[k];
    end
    r.cmp_a = phase_count(ph[0] - (mx + mn) + vbus * 32768, per, vbus * 65536);
    r.cmp_b = phase_count(ph[1] - (mx + mn) + vbus * 32768, per, vbus * 65536);
    r.cmp_c = phase_count(ph[2] - (mx + mn) + vbus * 32768, per, vbus * 65536);
    return r;
  endfunction

  always @(posedge clk_i) begin
    duty_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        duty_q.push_back(predict_duty(volt_alpha_i, volt_beta_i, bus_voltage_i, period_i));
      if (out_valid_i && !out_stall_i) begin
        if (duty_q.size() == 0) begin
          $error("result with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = duty_q.pop_front();
          if (want != {compare_a_i, compare_b_i, compare_c_i, was_limited_i, bus_fault_i}) begin
            if (want.cmp_a != compare_a_i)
              $error("compare_a expected %0d got %0d", want.cmp_a, compare_a_i);
            if (want.cmp_b != compare_b_i)
              $error("compare_b expected %0d got %0d", want.cmp_b, compare_b_i);
            if (want.cmp_c != compare_c_i)
              $error("compare_c expected %0d got %0d", want.cmp_c, compare_c_i);
            if (want.lim != was_limited_i)
              $error("was_limited expected %0d got %0d", want.lim, was_limited_i);
            if (want.fault != bus_fault_i)
              $error("bus_fault expected %0d got %0d", want.fault, bus_fault_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
    pending_o <= duty_q.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed and random voltage vectors into the SVPWM core over several
// timer periods, with random gaps and stalls, and reports the verdict.
// ----------------------------------------------------------------------------
module tb;

  localparam int Latency   = 59;
  localparam int WatchLim  = 5000;
  localparam int NumRandom = 1040;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] volt_alpha = '0;
  logic [15:0] volt_beta = '0;
  logic [15:0] bus_voltage = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] compare_a, compare_b, compare_c;
  logic        was_limited, bus_fault;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic [15:0] period_mirror = svpwm_pkg::PERIOD_RESET;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;
  bit          stall_on = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  svpwm_min_max_duty_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .volt_alpha_i(volt_alpha), .volt_beta_i(volt_beta), .bus_voltage_i(bus_voltage),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .compare_a_o(compare_a), .compare_b_o(compare_b), .compare_c_o(compare_c),
    .was_limited_o(was_limited), .bus_fault_o(bus_fault),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  svpwm_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .volt_alpha_i(volt_alpha), .volt_beta_i(volt_beta), .bus_voltage_i(bus_voltage),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .compare_a_i(compare_a), .compare_b_i(compare_b), .compare_c_i(compare_c),
    .was_limited_i(was_limited), .bus_fault_i(bus_fault),
    .period_i(period_mirror), .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: random stalls, or one long hold-off on request
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (hold_off) out_stall <= 1'b1;
    else if (stall_on) out_stall <= (r < 40) || (r < 43 && out_stall);
    else out_stall <= 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLim) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_period(logic [15:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= svpwm_pkg::ADDR_PERIOD; pwdata <= {16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    period_mirror <= val;
  endtask

  task automatic send_vector(logic [15:0] va, logic [15:0] vb, logic [15:0] vbus,
                             bit gaps);
    int g;
    if (gaps) begin
      g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    in_valid <= 1'b1; volt_alpha <= va; volt_beta <= vb; bus_voltage <= vbus;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (Latency + 5) @(posedge clk);
  endtask

  task automatic random_vector(bit gaps);
    logic [15:0] va, vb, vbus;
    int mode;
    mode = $urandom_range(0, 9);
    va   = $urandom;
    vb   = $urandom;
    vbus = $urandom;
    if (mode == 0) vbus = $urandom_range(0, 3);
    else if (mode < 4) begin
      // keep the vector mostly inside the linear range
      vbus = $urandom_range(16'h4000, 16'hFFFF);
      va = $signed(va) >>> 2;
      vb = $signed(vb) >>> 2;
    end
    send_vector(va, vb, vbus, gaps);
  endtask

  initial begin
    logic [15:0] periods[5];
    periods = '{16'hFFFF, 16'd1, 16'd0, 16'd1000, 16'h8000};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero bus, tiny bus, overshoot
    send_vector(16'h0000, 16'h0000, 16'd1000, 1'b0);
    send_vector(16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_vector(16'h7FFF, 16'h8000, 16'h0000, 1'b0);
    send_vector(16'h7FFF, 16'h7FFF, 16'hFFFF, 1'b0);
    send_vector(16'h8000, 16'h8000, 16'hFFFF, 1'b0);
    send_vector(16'h8000, 16'h7FFF, 16'd1, 1'b0);
    send_vector(16'd5, 16'hFFFB, 16'd1, 1'b0);
    send_vector(16'd1, 16'd0, 16'd2, 1'b0);
    send_vector(16'h7FFF, 16'h0000, 16'd100, 1'b0);
    send_vector(16'h0000, 16'h8000, 16'd100, 1'b0);
    send_vector(16'd300, 16'hFF00, 16'd1000, 1'b0);
    send_vector(16'hFFFF, 16'h0001, 16'h8000, 1'b0);
    drain();

    stall_on = 1'b1;
    for (int ph = 0; ph < 5; ph++) begin
      write_period(periods[ph]);
      for (int i = 0; i < NumRandom / 5; i++) random_vector(1'b1);
      drain();
    end

    // long hold-off at the output while items keep coming
    write_period(16'd4321);
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 150; i++) random_vector(1'b0);
    join
    drain();

    if (fail_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
